@@ rtl/core/sic_pkg.sv @@
// ----------------------------------------------------------------------------
// sic_pkg
// Widths, register indexes and step counts shared by the shadow coverage block.
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int COORD_W = 31;                 // segment and point coordinates
    localparam int LINE_W  = 32;                 // light path height register
    localparam int S_W     = 32;                 // path depth below the axis
    localparam int D_W     = 32;                 // query_y plus depth
    localparam int PROD_W  = 64;                 // scaled coordinates and products
    localparam int FRAC_W  = 24;                 // result fraction bits
    localparam int OUT_W   = 56;                 // result width
    localparam int CFG_W   = 2;                  // register index width
    localparam int DIV_STEPS = PROD_W + FRAC_W;  // one quotient bit per step
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] CFG_LINE_Y  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_START_X = 2'd1;
    localparam logic [CFG_W-1:0] CFG_END_X   = 2'd2;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

endpackage

@@ rtl/core/sic_in_if.sv @@
// ----------------------------------------------------------------------------
// sic_in_if
// Input channel: append or query item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sic_in_if import sic_pkg::*; ;
    logic               valid;
    logic               ready;
    logic               action;
    logic [COORD_W-1:0] seg_left;
    logic [COORD_W-1:0] seg_right;
    logic [COORD_W-1:0] query_x;
    logic [COORD_W-1:0] query_y;

    modport source (output valid, action, seg_left, seg_right, query_x, query_y,
                    input ready);
    modport sink (input valid, action, seg_left, seg_right, query_x, query_y,
                  output ready);
endinterface

@@ rtl/core/sic_out_if.sv @@
// ----------------------------------------------------------------------------
// sic_out_if
// Output channel: shaded time result with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sic_out_if import sic_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] shade_time;

    modport source (output valid, shade_time, input ready);
    modport sink (input valid, shade_time, output ready);
endinterface

@@ rtl/core/sic_ram.sv @@
// ----------------------------------------------------------------------------
// sic_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sic_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/shadow_interval_coverage.sv @@
// ----------------------------------------------------------------------------
// shadow_interval_coverage
// Shaded time of a light moving below a row of blocking segments on the axis.
// ----------------------------------------------------------------------------
// An append item is taken while idle and yields no result; appends beyond
// MAX_SEGMENTS are dropped. A query item keeps the block busy (input not ready)
// until its result is loaded into the output: one shared 32x32 multiplier forms
// the projected window, two binary searches over the segment RAMs read, multiply
// and compare at each probe, and a restoring divider produces one quotient bit
// per cycle for the 88-bit scaled quotient. Queries with nothing to cover skip
// the divider and go straight to the result state. A result waiting at the
// output does not block new items.
module shadow_interval_coverage import sic_pkg::*; #(
    parameter int MAX_SEGMENTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_addr,
    input  logic [LINE_W-1:0] i_cfg_wdata,
    sic_in_if.sink            i_in,
    sic_out_if.source         o_out
);

    localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MA, ST_MB, ST_MC, ST_MD,
        ST_SADDR, ST_SMUL, ST_SCMP,
        ST_FA, ST_FB, ST_FC, ST_FD, ST_FE, ST_FF, ST_FG,
        ST_DIV, ST_RES
    } t_state;

    t_state               r_state;
    logic [LINE_W-1:0]    r_line_y;
    logic [COORD_W-1:0]   r_start_x;
    logic [COORD_W-1:0]   r_end_x;
    logic [CNT_W-1:0]     r_count;
    logic [COORD_W-1:0]   r_last_right;
    logic [COORD_W-1:0]   r_last_gap;
    logic [COORD_W-1:0]   r_qx;
    logic [COORD_W-1:0]   r_qy;
    logic [S_W-1:0]       r_s;
    logic [D_W-1:0]       r_d;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    r_base;
    logic [PROD_W-1:0]    r_p1;
    logic [PROD_W-1:0]    r_p2;
    logic                 r_mode;
    logic [CNT_W-1:0]     r_lo;
    logic [CNT_W-1:0]     r_hi;
    logic [CNT_W-1:0]     r_i;
    logic [CNT_W-1:0]     r_j;
    logic [COORD_W-1:0]   r_lv;
    logic [COORD_W-1:0]   r_rv;
    logic [COORD_W-1:0]   r_gj;
    logic [COORD_W-1:0]   r_gd;
    logic [PROD_W-1:0]    r_lo_end;
    logic [PROD_W-1:0]    r_hi_end;
    logic [PROD_W-1:0]    r_span;
    logic [PROD_W-1:0]    r_dvd;
    logic [COORD_W-1:0]   r_rem;
    logic [OUT_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [OUT_W-1:0]     r_res;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    logic                 in_acc;
    logic                 out_free;
    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid;
    logic [ADDR_W-1:0]    left_raddr;
    logic [ADDR_W-1:0]    right_raddr;
    logic [ADDR_W-1:0]    gap_raddr;
    logic [COORD_W-1:0]   left_rd;
    logic [COORD_W-1:0]   right_rd;
    logic [COORD_W-1:0]   gap_rd;
    logic                 app_we;
    logic [COORD_W-1:0]   n_gap;
    logic [S_W-1:0]       n_s;
    logic [D_W:0]         n_d;
    logic [S_W-1:0]       mul_a;
    logic [S_W-1:0]       mul_b;
    logic [PROD_W-1:0]    n_prod;
    logic                 probe_hit;
    logic [COORD_W:0]     div_t;
    logic                 div_ge;
    logic [COORD_W:0]     div_diff;
    logic [OUT_W-1:0]     n_quo;
    logic                 query_empty;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.shade_time = r_out_data;
    assign out_free    = !r_out_valid || o_out.ready;

    // append path: running gap sum from the last written entry
    assign app_we = in_acc && (i_in.action == ACT_APPEND)
                    && (r_count < CNT_W'(MAX_SEGMENTS));
    assign n_gap  = (r_count == '0) ? '0
                    : COORD_W'(r_last_gap + i_in.seg_left - r_last_right);

    assign n_s = r_line_y[LINE_W-1] ? S_W'(~r_line_y + 1'b1) : S_W'(1);
    assign n_d = (D_W+1)'(i_in.query_y) + (D_W+1)'(n_s);
    assign query_empty = (i_in.query_y == '0) || (r_end_x <= r_start_x)
                         || (r_count == '0);

    assign mid_sum = (CNT_W+1)'(r_lo) + (CNT_W+1)'(r_hi);
    assign mid     = mid_sum[CNT_W:1];

    always_comb begin
        left_raddr  = mid[ADDR_W-1:0];
        right_raddr = mid[ADDR_W-1:0];
        gap_raddr   = r_j[ADDR_W-1:0];
        if (r_state == ST_FA) begin
            left_raddr  = r_i[ADDR_W-1:0];
            right_raddr = r_j[ADDR_W-1:0];
        end
        if (r_state == ST_FB) begin
            gap_raddr = r_i[ADDR_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = S_W'(r_d);
        mul_b = '0;
        case (r_state)
            ST_MA: begin
                mul_a = S_W'(r_qx);
                mul_b = r_s;
            end
            ST_MB: begin
                mul_a = S_W'(r_start_x);
                mul_b = S_W'(r_qy);
            end
            ST_MC: begin
                mul_a = S_W'(r_end_x);
                mul_b = S_W'(r_qy);
            end
            ST_SMUL: mul_b = S_W'(r_mode ? left_rd : right_rd);
            ST_FC:   mul_b = S_W'(r_lv);
            ST_FD:   mul_b = S_W'(r_rv);
            ST_FE:   mul_b = S_W'(r_gd);
            default: mul_b = '0;
        endcase
    end
    assign n_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign probe_hit = r_mode ? (r_prod < r_p2) : (r_prod <= r_p1);

    // restoring division step on the remainder
    assign div_t    = {r_rem, r_dvd[PROD_W-1]};
    assign div_ge   = div_t >= (COORD_W+1)'(r_qy);
    assign div_diff = div_t - (COORD_W+1)'(r_qy);
    assign n_quo    = {r_quo[OUT_W-2:0], div_ge};

    sic_ram #(.WIDTH(COORD_W), .DEPTH(MAX_SEGMENTS)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.seg_left),
        .i_raddr (left_raddr),
        .o_rdata (left_rd)
    );

    sic_ram #(.WIDTH(COORD_W), .DEPTH(MAX_SEGMENTS)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_in.seg_right),
        .i_raddr (right_raddr),
        .o_rdata (right_rd)
    );

    sic_ram #(.WIDTH(COORD_W), .DEPTH(MAX_SEGMENTS)) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (n_gap),
        .i_raddr (gap_raddr),
        .o_rdata (gap_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_line_y    <= '1;
            r_start_x   <= '0;
            r_end_x     <= COORD_W'(1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_LINE_Y:  r_line_y  <= i_cfg_wdata;
                    CFG_START_X: r_start_x <= i_cfg_wdata[COORD_W-1:0];
                    CFG_END_X:   r_end_x   <= i_cfg_wdata[COORD_W-1:0];
                    default: ;
                endcase
            end

            // the result state loads the output itself
            if (r_out_valid && o_out.ready && (r_state != ST_RES)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (app_we) begin
                        r_count      <= r_count + 1'b1;
                        r_last_right <= i_in.seg_right;
                        r_last_gap   <= n_gap;
                    end
                    if (in_acc && (i_in.action == ACT_QUERY)) begin
                        r_qx <= i_in.query_x;
                        r_qy <= i_in.query_y;
                        r_s  <= n_s;
                        r_d  <= n_d[D_W-1:0];
                        if (query_empty) begin
                            r_res   <= '0;
                            r_state <= ST_RES;
                        end else begin
                            r_state <= ST_MA;
                        end
                    end
                end
                ST_MA: begin
                    r_prod  <= n_prod;
                    r_state <= ST_MB;
                end
                ST_MB: begin
                    r_base  <= r_prod;
                    r_prod  <= n_prod;
                    r_state <= ST_MC;
                end
                ST_MC: begin
                    r_p1    <= r_base + r_prod;
                    r_prod  <= n_prod;
                    r_state <= ST_MD;
                end
                ST_MD: begin
                    r_p2    <= r_base + r_prod;
                    r_mode  <= 1'b0;
                    r_lo    <= '0;
                    r_hi    <= r_count;
                    r_state <= ST_SADDR;
                end
                ST_SADDR: begin
                    if (r_lo < r_hi) begin
                        r_state <= ST_SMUL;
                    end else if (!r_mode) begin
                        // first search done: entries ending at or left of the window
                        r_i    <= r_lo;
                        r_mode <= 1'b1;
                        r_lo   <= '0;
                        r_hi   <= r_count;
                    end else if ((r_lo == '0) || (r_i >= r_lo)) begin
                        r_res   <= '0;
                        r_state <= ST_RES;
                    end else begin
                        r_j     <= r_lo - 1'b1;
                        r_state <= ST_FA;
                    end
                end
                ST_SMUL: begin
                    r_prod  <= n_prod;
                    r_state <= ST_SCMP;
                end
                ST_SCMP: begin
                    if (probe_hit) begin
                        r_lo <= mid + 1'b1;
                    end else begin
                        r_hi <= mid;
                    end
                    r_state <= ST_SADDR;
                end
                ST_FA: r_state <= ST_FB;
                ST_FB: begin
                    r_lv    <= left_rd;
                    r_rv    <= right_rd;
                    r_gj    <= gap_rd;
                    r_state <= ST_FC;
                end
                ST_FC: begin
                    r_gd    <= r_gj - gap_rd;
                    r_prod  <= n_prod;
                    r_state <= ST_FD;
                end
                ST_FD: begin
                    r_lo_end <= (r_prod < r_p1) ? r_p1 : r_prod;
                    r_prod   <= n_prod;
                    r_state  <= ST_FE;
                end
                ST_FE: begin
                    r_hi_end <= (r_prod > r_p2) ? r_p2 : r_prod;
                    r_prod   <= n_prod;
                    r_state  <= ST_FF;
                end
                ST_FF: begin
                    if (r_hi_end <= r_lo_end) begin
                        r_res   <= '0;
                        r_state <= ST_RES;
                    end else begin
                        r_span  <= r_hi_end - r_lo_end;
                        r_state <= ST_FG;
                    end
                end
                ST_FG: begin
                    // r_prod holds the scaled gap length inside the window
                    if (r_span <= r_prod) begin
                        r_res   <= '0;
                        r_state <= ST_RES;
                    end else begin
                        r_dvd     <= r_span - r_prod;
                        r_rem     <= '0;
                        r_quo     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_dvd     <= {r_dvd[PROD_W-2:0], 1'b0};
                    r_rem     <= div_ge ? div_diff[COORD_W-1:0] : div_t[COORD_W-1:0];
                    r_quo     <= n_quo;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_res   <= n_quo;
                        r_state <= ST_RES;
                    end
                end
                ST_RES: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond capacity");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SMUL || r_state == ST_SCMP) |-> (r_lo < r_hi && r_hi <= r_count))
        else $error("binary search bounds out of order");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_qy))
        else $error("divider remainder not below divisor");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.action == ACT_QUERY) |=> (r_state != ST_IDLE))
        else $error("query item did not start work");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RES && !out_free) |=> (r_state == ST_RES && $stable(r_res)))
        else $error("finished result lost while output busy");

endmodule
